// ----- rtl/glfs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glfs_pkg
// Shared types, register map, reset values and state codes of the link
// failover supervisor.
// ----------------------------------------------------------------------------
package glfs_pkg;

	localparam int TIMER_BITS_DEF = 10;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 10;
	localparam int WAIT_W         = 10;
	localparam int CNT_W          = 8;
	localparam int SWAP_W         = 16;
	localparam int CODE_W         = 3;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STARTUP_DELAY  = 3'd0,
		CFG_AUTONEG_WAIT   = 3'd1,
		CFG_LONG_CHECK     = 3'd2,
		CFG_SHORT_CHECK    = 3'd3,
		CFG_PING_TIMEOUT   = 3'd4,
		CFG_RELAY_SETTLE   = 3'd5,
		CFG_PING_COUNT     = 3'd6,
		CFG_MAX_LOSS       = 3'd7
	} cfg_idx_t;

	localparam logic [WAIT_W-1:0] RST_STARTUP_DELAY = 10'd10;
	localparam logic [WAIT_W-1:0] RST_AUTONEG_WAIT  = 10'd450;
	localparam logic [WAIT_W-1:0] RST_LONG_CHECK    = 10'd600;
	localparam logic [WAIT_W-1:0] RST_SHORT_CHECK   = 10'd50;
	localparam logic [WAIT_W-1:0] RST_PING_TIMEOUT  = 10'd100;
	localparam logic [WAIT_W-1:0] RST_RELAY_SETTLE  = 10'd40;
	localparam logic [CNT_W-1:0]  RST_PING_COUNT    = 8'd5;
	localparam logic [CNT_W-1:0]  RST_MAX_LOSS      = 8'd2;

	// reported state numbers
	localparam logic [CODE_W-1:0] CODE_INIT   = 3'd0;
	localparam logic [CODE_W-1:0] CODE_WAIT   = 3'd1;
	localparam logic [CODE_W-1:0] CODE_PING   = 3'd2;
	localparam logic [CODE_W-1:0] CODE_VERIFY = 3'd3;
	localparam logic [CODE_W-1:0] CODE_SWAP   = 3'd4;
	localparam logic [CODE_W-1:0] CODE_SETTLE = 3'd5;
	localparam logic [CODE_W-1:0] CODE_RECONF = 3'd6;

	typedef enum logic [6:0] {
		S_INIT   = 7'b0000001,
		S_WAIT   = 7'b0000010,
		S_PING   = 7'b0000100,
		S_VERIFY = 7'b0001000,
		S_SWAP   = 7'b0010000,
		S_SETTLE = 7'b0100000,
		S_RECONF = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [WAIT_W-1:0] startup_delay;
		logic [WAIT_W-1:0] autoneg_wait;
		logic [WAIT_W-1:0] long_check_wait;
		logic [WAIT_W-1:0] short_check_wait;
		logic [WAIT_W-1:0] ping_timeout;
		logic [WAIT_W-1:0] relay_settle;
		logic [CNT_W-1:0]  ping_count;
		logic [CNT_W-1:0]  max_loss_exclusive;
	} cfg_regs_t;

	typedef struct packed {
		logic             tick;
		logic             lan_up;
		logic             manual_mode;
		logic             ping_done;
		logic [CNT_W-1:0] pkts_sent;
		logic [CNT_W-1:0] pkts_lost;
		logic             ts_relay_readback;
		logic             voip_relay_readback;
		logic             banks_differ;
	} item_t;

	typedef struct packed {
		logic [CODE_W-1:0] state_now;
		logic              ping_launch;
		logic              ping_release;
		logic              ts_relay_write;
		logic              ts_relay_value;
		logic              voip_relay_write;
		logic              voip_relay_value;
		logic              bank_load;
		logic              bank_select;
		logic              reinit_request;
		logic              reconf_busy;
		logic [SWAP_W-1:0] switch_count;
	} result_t;

	function automatic logic [CODE_W-1:0] state_code(input state_t s);
		logic [CODE_W-1:0] c;
		case (s)
			S_WAIT:   c = CODE_WAIT;
			S_PING:   c = CODE_PING;
			S_VERIFY: c = CODE_VERIFY;
			S_SWAP:   c = CODE_SWAP;
			S_SETTLE: c = CODE_SETTLE;
			S_RECONF: c = CODE_RECONF;
			default:  c = CODE_INIT;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/glfs_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glfs_if
// Valid/ready channels of the supervisor: input item, result, register write.
// ----------------------------------------------------------------------------
interface glfs_item_if;
	logic            valid;
	logic            ready;
	glfs_pkg::item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface glfs_result_if;
	logic              valid;
	logic              ready;
	glfs_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface glfs_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [glfs_pkg::CFG_IDX_W-1:0]  index;
	logic [glfs_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/gateway_link_failover_supervisor_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gateway_link_failover_supervisor_core
// Link failover supervisor: one supervision pass per input beat, one result
// beat per pass.
// ----------------------------------------------------------------------------
//  channel  modport  beat carries
//  item     sink     tick, link, manual, ping report, relay readbacks
//  result   source   state, ping/relay/bank/reinit commands, flags, swap count
//  cfg      sink     register index and write data, always ready
//
//  Item beat to result beat: input register, then the pass logic into the
//  result register.
//  One item per cycle while results are taken; the pass is combinational.
//  A stalled result holds the result register; the input register takes one
//  more item and holds it, and the pass advances once the result moves on.
//  Reset loads register defaults and puts the supervisor in init.
// ----------------------------------------------------------------------------
module gateway_link_failover_supervisor_core #(
	parameter int TIMER_BITS = glfs_pkg::TIMER_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	glfs_item_if.sink      item,
	glfs_result_if.source  result,
	glfs_cfg_if.sink       cfg
);

	glfs_pkg::item_t     item_s1;
	logic                valid_s1;
	glfs_pkg::result_t   result_s2;
	logic                valid_s2;
	glfs_pkg::cfg_regs_t regs;
	glfs_pkg::result_t   pass_res;
	logic                advance;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	glfs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.regs     (regs)
	);

	glfs_fsm #(
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.regs   (regs),
		.res    (pass_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.valid && item.ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready)
			item_s1 <= item.data;
		if (advance)
			result_s2 <= pass_res;
	end

	assign result.valid = valid_s2;
	assign result.data  = result_s2;

endmodule
`default_nettype wire

// ----- rtl/glfs_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glfs_cfg
// Configuration register file; one register written per write beat.
// ----------------------------------------------------------------------------
module glfs_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [glfs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [glfs_pkg::CFG_DATA_W-1:0] wr_data,
	output glfs_pkg::cfg_regs_t                  regs
);

	glfs_pkg::cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.startup_delay      <= glfs_pkg::RST_STARTUP_DELAY;
			regs_q.autoneg_wait       <= glfs_pkg::RST_AUTONEG_WAIT;
			regs_q.long_check_wait    <= glfs_pkg::RST_LONG_CHECK;
			regs_q.short_check_wait   <= glfs_pkg::RST_SHORT_CHECK;
			regs_q.ping_timeout       <= glfs_pkg::RST_PING_TIMEOUT;
			regs_q.relay_settle       <= glfs_pkg::RST_RELAY_SETTLE;
			regs_q.ping_count         <= glfs_pkg::RST_PING_COUNT;
			regs_q.max_loss_exclusive <= glfs_pkg::RST_MAX_LOSS;
		end else if (wr_en) begin
			case (glfs_pkg::cfg_idx_t'(wr_index))
				glfs_pkg::CFG_STARTUP_DELAY: regs_q.startup_delay    <= wr_data;
				glfs_pkg::CFG_AUTONEG_WAIT:  regs_q.autoneg_wait     <= wr_data;
				glfs_pkg::CFG_LONG_CHECK:    regs_q.long_check_wait  <= wr_data;
				glfs_pkg::CFG_SHORT_CHECK:   regs_q.short_check_wait <= wr_data;
				glfs_pkg::CFG_PING_TIMEOUT:  regs_q.ping_timeout     <= wr_data;
				glfs_pkg::CFG_RELAY_SETTLE:  regs_q.relay_settle     <= wr_data;
				glfs_pkg::CFG_PING_COUNT:
					regs_q.ping_count <= wr_data[glfs_pkg::CNT_W-1:0];
				glfs_pkg::CFG_MAX_LOSS:
					regs_q.max_loss_exclusive <= wr_data[glfs_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule
`default_nettype wire

// ----- rtl/glfs_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glfs_fsm
// Supervisor state and one supervision pass per step; the pass result is
// combinational from the state registers and the registered input item.
// ----------------------------------------------------------------------------
module glfs_fsm #(
	parameter int TIMER_BITS = glfs_pkg::TIMER_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire glfs_pkg::item_t     item,
	input  wire glfs_pkg::cfg_regs_t regs,
	output glfs_pkg::result_t       res
);

	localparam int CMP_W = (TIMER_BITS > glfs_pkg::WAIT_W) ? TIMER_BITS : glfs_pkg::WAIT_W;

	glfs_pkg::state_t                state_q, state_d;
	logic                            entering_q, entering_d;
	logic [TIMER_BITS-1:0]           timer_q, timer_d;
	logic [glfs_pkg::WAIT_W-1:0]     check_wait_q, check_wait_d;
	logic [1:0]                      link_pos_q, link_pos_d;
	logic                            reinit_pend_q, reinit_pend_d;
	logic                            reconf_q, reconf_d;
	logic                            rem_relay_q, rem_relay_d;
	logic [glfs_pkg::SWAP_W-1:0]     swaps_q, swaps_d;

	function automatic logic reached(input logic [TIMER_BITS-1:0] t,
		input logic [glfs_pkg::WAIT_W-1:0] lim);
		return CMP_W'(t) >= CMP_W'(lim);
	endfunction

	always_comb begin
		logic want;
		logic switched;
		state_d       = state_q;
		entering_d    = entering_q;
		timer_d       = timer_q;
		check_wait_d  = check_wait_q;
		link_pos_d    = link_pos_q;
		reinit_pend_d = reinit_pend_q;
		reconf_d      = reconf_q;
		rem_relay_d   = rem_relay_q;
		swaps_d       = swaps_q;
		res           = '0;
		want          = 1'b0;
		switched      = 1'b0;

		if (item.tick && (timer_q != {TIMER_BITS{1'b1}}))
			timer_d = timer_q + 1'b1;

		if (item.manual_mode) begin
			state_d    = glfs_pkg::S_INIT;
			entering_d = 1'b1;
		end else begin
			case (state_q)
				glfs_pkg::S_WAIT: begin
					if (entering_q) begin
						entering_d = 1'b0;
						timer_d    = '0;
					end
					if (reached(timer_d, check_wait_q) && item.lan_up) begin
						state_d    = glfs_pkg::S_PING;
						entering_d = 1'b1;
					end
				end
				glfs_pkg::S_PING: begin
					res.ping_launch = 1'b1;
					state_d         = glfs_pkg::S_VERIFY;
					entering_d      = 1'b1;
				end
				glfs_pkg::S_VERIFY: begin
					if (entering_q) begin
						entering_d = 1'b0;
						timer_d    = '0;
					end
					if (item.ping_done) begin
						if ((item.pkts_sent == regs.ping_count) &&
						    (item.pkts_lost < regs.max_loss_exclusive)) begin
							check_wait_d = regs.long_check_wait;
							state_d      = glfs_pkg::S_WAIT;
						end else begin
							state_d = glfs_pkg::S_SWAP;
						end
						entering_d       = 1'b1;
						res.ping_release = 1'b1;
					end
					if (reached(timer_d, regs.ping_timeout)) begin
						state_d    = glfs_pkg::S_SWAP;
						entering_d = 1'b1;
					end
				end
				glfs_pkg::S_SWAP: begin
					case (link_pos_q)
						2'd0:    link_pos_d = item.banks_differ ? 2'd1 : 2'd2;
						2'd1:    link_pos_d = 2'd2;
						2'd2:    link_pos_d = item.banks_differ ? 2'd3 : 2'd0;
						default: link_pos_d = 2'd0;
					endcase
					res.bank_load   = 1'b1;
					res.bank_select = link_pos_d[0];
					want            = link_pos_d[1];
					if (item.ts_relay_readback != want) begin
						res.ts_relay_write = 1'b1;
						res.ts_relay_value = want;
						rem_relay_d        = want;
						switched           = 1'b1;
					end
					if (item.voip_relay_readback != want) begin
						res.voip_relay_write = 1'b1;
						res.voip_relay_value = want;
					end
					swaps_d    = swaps_q + 1'b1;
					state_d    = switched ? glfs_pkg::S_SETTLE : glfs_pkg::S_RECONF;
					entering_d = 1'b1;
				end
				glfs_pkg::S_SETTLE: begin
					if (entering_q) begin
						entering_d = 1'b0;
						timer_d    = '0;
					end
					if (reached(timer_d, regs.relay_settle)) begin
						state_d    = glfs_pkg::S_RECONF;
						entering_d = 1'b1;
					end
				end
				glfs_pkg::S_RECONF: begin
					if (entering_q) begin
						entering_d = 1'b0;
						timer_d    = '0;
					end
					if (!reconf_q && !reinit_pend_q) begin
						reconf_d           = 1'b1;
						reinit_pend_d      = 1'b1;
						res.reinit_request = 1'b1;
					end
					if (reached(timer_d, regs.autoneg_wait)) begin
						reconf_d      = 1'b0;
						check_wait_d  = regs.short_check_wait;
						reinit_pend_d = 1'b0;
						state_d       = glfs_pkg::S_WAIT;
						entering_d    = 1'b1;
					end
				end
				default: begin
					// init, and any code outside the set
					state_d = glfs_pkg::S_INIT;
					if (entering_q) begin
						entering_d = 1'b0;
						timer_d    = '0;
						if (item.ts_relay_readback != rem_relay_q) begin
							res.ts_relay_write = 1'b1;
							res.ts_relay_value = rem_relay_q;
						end
						reinit_pend_d = 1'b0;
					end
					if (reached(timer_d, regs.startup_delay)) begin
						check_wait_d = regs.autoneg_wait;
						link_pos_d   = 2'd0;
						state_d      = glfs_pkg::S_WAIT;
						entering_d   = 1'b1;
					end
				end
			endcase
		end

		res.state_now    = glfs_pkg::state_code(state_d);
		res.reconf_busy  = reconf_d;
		res.switch_count = swaps_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= glfs_pkg::S_INIT;
			entering_q    <= 1'b1;
			timer_q       <= '0;
			check_wait_q  <= '0;
			link_pos_q    <= '0;
			reinit_pend_q <= 1'b0;
			reconf_q      <= 1'b0;
			rem_relay_q   <= 1'b0;
			swaps_q       <= '0;
		end else if (step) begin
			state_q       <= state_d;
			entering_q    <= entering_d;
			timer_q       <= timer_d;
			check_wait_q  <= check_wait_d;
			link_pos_q    <= link_pos_d;
			reinit_pend_q <= reinit_pend_d;
			reconf_q      <= reconf_d;
			rem_relay_q   <= rem_relay_d;
			swaps_q       <= swaps_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/glfs_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glfs_checker
// Port-level checks of the supervisor, bound to the top level.
// ----------------------------------------------------------------------------
module glfs_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire glfs_pkg::result_t res_data
);

	logic [glfs_pkg::SWAP_W-1:0] last_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_count_q <= '0;
		else if (res_valid && res_ready)
			last_count_q <= res_data.switch_count;
	end

	// hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result beat dropped or changed while stalled");

	// swap count advances by one exactly on a bank load
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |->
			res_data.switch_count == last_count_q + {15'd0, res_data.bank_load})
		else $error("switch count out of step with bank loads");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.ping_launch |->
			res_data.state_now == glfs_pkg::CODE_VERIFY && !res_data.bank_load)
		else $error("ping start outside entry to verify");

	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.ping_release |->
			res_data.state_now == glfs_pkg::CODE_WAIT ||
			res_data.state_now == glfs_pkg::CODE_SWAP)
		else $error("ping stop leads to an unexpected state");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.bank_load |->
			(res_data.state_now == glfs_pkg::CODE_SETTLE) == res_data.ts_relay_write)
		else $error("settle entered without terminal-server relay switch");

endmodule

bind gateway_link_failover_supervisor_core glfs_checker u_glfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);
`default_nettype wire

// ----- tb/tb_gateway_link_failover_supervisor_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gateway_link_failover_supervisor_core
// Self-checking bench for the link failover supervisor. A queue-fed driver
// sends supervision passes, and a shadow copy of the state machine predicts
// every result beat. A monitor compares each result beat field by field.
// A directed walk through the failover cycle comes first. Random phases then
// run under several register settings and idle patterns, and one phase holds
// the wait state long enough to saturate the state timer.
// ----------------------------------------------------------------------------
module tb_gateway_link_failover_supervisor_core;

	localparam int TMR_W = glfs_pkg::TIMER_BITS_DEF;
	localparam int REG_W = glfs_pkg::WAIT_W;
	localparam int CNT_W = glfs_pkg::CNT_W;
	localparam int FLD_W = glfs_pkg::SWAP_W;
	localparam logic [TMR_W-1:0] TMR_MAX = '1;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		glfs_pkg::item_t it;
		logic            hold;
	} pend_t;

	typedef struct packed {
		glfs_pkg::cfg_idx_t                   idx;
		logic [glfs_pkg::CFG_DATA_W-1:0] val;
	} reg_write_t;

	logic clk;
	logic arst_n;

	glfs_item_if   item_ch ();
	glfs_result_if res_ch ();
	glfs_cfg_if    cfg_ch ();

	gateway_link_failover_supervisor_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	pend_t             pass_queue[$];
	glfs_pkg::result_t pass_want_q[$];
	reg_write_t        reg_write_q[$];

	int unsigned send_pct;
	int unsigned recv_pct;
	int unsigned err_count;
	int unsigned result_beats;
	int unsigned quiet_cycles;

	// shadow of the supervisor
	logic [REG_W-1:0]            reg_val [8];
	logic [glfs_pkg::CODE_W-1:0] sv_state;
	logic                        sv_entering;
	logic [TMR_W-1:0]            sv_timer;
	logic [REG_W-1:0]            sv_check_wait;
	logic [1:0]                  sv_pos;
	logic                        sv_reinit_pend;
	logic                        sv_reconf;
	logic                        sv_mem_relay;
	logic [FLD_W-1:0]            sv_swaps;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n         = 1'b0;
		item_ch.valid  = 1'b0;
		item_ch.data   = '0;
		res_ch.ready   = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = '0;
		cfg_ch.data    = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic void enter_state(logic [glfs_pkg::CODE_W-1:0] s);
		sv_state    = s;
		sv_entering = 1'b1;
	endfunction

	function automatic bit first_pass();
		if (sv_entering) begin
			sv_entering = 1'b0;
			sv_timer    = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic glfs_pkg::result_t supervise_pass(glfs_pkg::item_t it);
		glfs_pkg::result_t r;
		logic              want;
		r = '0;
		if (it.tick && sv_timer != TMR_MAX)
			sv_timer = sv_timer + 1'b1;
		if (sv_state > glfs_pkg::CODE_RECONF)
			sv_state = glfs_pkg::CODE_INIT;
		if (it.manual_mode) begin
			enter_state(glfs_pkg::CODE_INIT);
		end else begin
			case (sv_state)
				glfs_pkg::CODE_INIT: begin
					if (first_pass()) begin
						if (it.ts_relay_readback != sv_mem_relay) begin
							r.ts_relay_write = 1'b1;
							r.ts_relay_value = sv_mem_relay;
						end
						sv_reinit_pend = 1'b0;
					end
					if (sv_timer >= reg_val[glfs_pkg::CFG_STARTUP_DELAY]) begin
						sv_check_wait = reg_val[glfs_pkg::CFG_AUTONEG_WAIT];
						sv_pos        = 2'd0;
						enter_state(glfs_pkg::CODE_WAIT);
					end
				end
				glfs_pkg::CODE_WAIT: begin
					void'(first_pass());
					if (sv_timer >= sv_check_wait && it.lan_up)
						enter_state(glfs_pkg::CODE_PING);
				end
				glfs_pkg::CODE_PING: begin
					r.ping_launch = 1'b1;
					enter_state(glfs_pkg::CODE_VERIFY);
				end
				glfs_pkg::CODE_VERIFY: begin
					void'(first_pass());
					if (it.ping_done) begin
						if (it.pkts_sent == reg_val[glfs_pkg::CFG_PING_COUNT][CNT_W-1:0] &&
								it.pkts_lost < reg_val[glfs_pkg::CFG_MAX_LOSS][CNT_W-1:0]) begin
							sv_check_wait = reg_val[glfs_pkg::CFG_LONG_CHECK];
							enter_state(glfs_pkg::CODE_WAIT);
						end else begin
							enter_state(glfs_pkg::CODE_SWAP);
						end
						r.ping_release = 1'b1;
					end
					if (sv_timer >= reg_val[glfs_pkg::CFG_PING_TIMEOUT])
						enter_state(glfs_pkg::CODE_SWAP);
				end
				glfs_pkg::CODE_SWAP: begin
					case (sv_pos)
						2'd0: sv_pos = it.banks_differ ? 2'd1 : 2'd2;
						2'd1: sv_pos = 2'd2;
						2'd2: sv_pos = it.banks_differ ? 2'd3 : 2'd0;
						default: sv_pos = 2'd0;
					endcase
					r.bank_load   = 1'b1;
					r.bank_select = sv_pos[0];
					want          = sv_pos[1];
					if (it.ts_relay_readback != want) begin
						r.ts_relay_write = 1'b1;
						r.ts_relay_value = want;
						sv_mem_relay     = want;
					end
					if (it.voip_relay_readback != want) begin
						r.voip_relay_write = 1'b1;
						r.voip_relay_value = want;
					end
					sv_swaps = sv_swaps + 1'b1;
					enter_state(r.ts_relay_write ? glfs_pkg::CODE_SETTLE :
						glfs_pkg::CODE_RECONF);
				end
				glfs_pkg::CODE_SETTLE: begin
					void'(first_pass());
					if (sv_timer >= reg_val[glfs_pkg::CFG_RELAY_SETTLE])
						enter_state(glfs_pkg::CODE_RECONF);
				end
				default: begin
					void'(first_pass());
					if (!sv_reconf && !sv_reinit_pend) begin
						sv_reconf        = 1'b1;
						sv_reinit_pend   = 1'b1;
						r.reinit_request = 1'b1;
					end
					if (sv_timer >= reg_val[glfs_pkg::CFG_AUTONEG_WAIT]) begin
						sv_reconf      = 1'b0;
						sv_check_wait  = reg_val[glfs_pkg::CFG_SHORT_CHECK];
						sv_reinit_pend = 1'b0;
						enter_state(glfs_pkg::CODE_WAIT);
					end
				end
			endcase
		end
		r.state_now    = sv_state;
		r.reconf_busy  = sv_reconf;
		r.switch_count = sv_swaps;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: result beat %0d: %s", $time, result_beats, msg);
		err_count++;
	endtask

	task automatic check_field(string name, logic [FLD_W-1:0] got, logic [FLD_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// item driver: predicts each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid  <= 1'b0;
			item_ch.data   <= '0;
			sv_state       = glfs_pkg::CODE_INIT;
			sv_entering    = 1'b1;
			sv_timer       = '0;
			sv_check_wait  = '0;
			sv_pos         = 2'd0;
			sv_reinit_pend = 1'b0;
			sv_reconf      = 1'b0;
			sv_mem_relay   = 1'b0;
			sv_swaps       = '0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				pass_want_q.push_back(supervise_pass(item_ch.data));
				void'(pass_queue.pop_front());
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (pass_queue.size() != 0 &&
						!(pass_queue[0].hold && pass_want_q.size() != 0) &&
						$urandom_range(0, 99) >= send_pct) begin
					item_ch.valid <= 1'b1;
					item_ch.data  <= pass_queue[0].it;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		glfs_pkg::result_t got;
		glfs_pkg::result_t exp_r;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (pass_want_q.size() == 0) begin
					report_mismatch("result beat with no pass outstanding");
				end else begin
					exp_r = pass_want_q.pop_front();
					check_field("state_now", FLD_W'(got.state_now),
						FLD_W'(exp_r.state_now));
					check_field("ping_launch", FLD_W'(got.ping_launch),
						FLD_W'(exp_r.ping_launch));
					check_field("ping_release", FLD_W'(got.ping_release),
						FLD_W'(exp_r.ping_release));
					check_field("ts_relay_write", FLD_W'(got.ts_relay_write),
						FLD_W'(exp_r.ts_relay_write));
					check_field("ts_relay_value", FLD_W'(got.ts_relay_value),
						FLD_W'(exp_r.ts_relay_value));
					check_field("voip_relay_write", FLD_W'(got.voip_relay_write),
						FLD_W'(exp_r.voip_relay_write));
					check_field("voip_relay_value", FLD_W'(got.voip_relay_value),
						FLD_W'(exp_r.voip_relay_value));
					check_field("bank_load", FLD_W'(got.bank_load),
						FLD_W'(exp_r.bank_load));
					check_field("bank_select", FLD_W'(got.bank_select),
						FLD_W'(exp_r.bank_select));
					check_field("reinit_request", FLD_W'(got.reinit_request),
						FLD_W'(exp_r.reinit_request));
					check_field("reconf_busy", FLD_W'(got.reconf_busy),
						FLD_W'(exp_r.reconf_busy));
					check_field("switch_count", got.switch_count, exp_r.switch_count);
				end
				result_beats++;
			end
			res_ch.ready <= ($urandom_range(0, 99) >= recv_pct);
		end
	end

	// register write driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= '0;
			cfg_ch.data  <= '0;
			reg_val[glfs_pkg::CFG_STARTUP_DELAY] = glfs_pkg::RST_STARTUP_DELAY;
			reg_val[glfs_pkg::CFG_AUTONEG_WAIT]  = glfs_pkg::RST_AUTONEG_WAIT;
			reg_val[glfs_pkg::CFG_LONG_CHECK]    = glfs_pkg::RST_LONG_CHECK;
			reg_val[glfs_pkg::CFG_SHORT_CHECK]   = glfs_pkg::RST_SHORT_CHECK;
			reg_val[glfs_pkg::CFG_PING_TIMEOUT]  = glfs_pkg::RST_PING_TIMEOUT;
			reg_val[glfs_pkg::CFG_RELAY_SETTLE]  = glfs_pkg::RST_RELAY_SETTLE;
			reg_val[glfs_pkg::CFG_PING_COUNT]    = REG_W'(glfs_pkg::RST_PING_COUNT);
			reg_val[glfs_pkg::CFG_MAX_LOSS]      = REG_W'(glfs_pkg::RST_MAX_LOSS);
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index == glfs_pkg::CFG_PING_COUNT ||
						cfg_ch.index == glfs_pkg::CFG_MAX_LOSS)
					reg_val[cfg_ch.index] = REG_W'(cfg_ch.data[CNT_W-1:0]);
				else
					reg_val[cfg_ch.index] = cfg_ch.data;
				void'(reg_write_q.pop_front());
			end
			if (!cfg_ch.valid || cfg_ch.ready) begin
				if (reg_write_q.size() != 0) begin
					cfg_ch.valid <= 1'b1;
					cfg_ch.index <= reg_write_q[0].idx;
					cfg_ch.data  <= reg_write_q[0].val;
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// watchdog on cycles with no beat anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_gateway_link_failover_supervisor_core failed");
				$finish;
			end
		end
	end

	function automatic glfs_pkg::item_t mk(int tk, int lan, int man, int done,
			logic [CNT_W-1:0] sent, logic [CNT_W-1:0] lost, int ts, int vo, int dif);
		glfs_pkg::item_t it;
		it.tick                = tk[0];
		it.lan_up              = lan[0];
		it.manual_mode         = man[0];
		it.ping_done           = done[0];
		it.pkts_sent           = sent;
		it.pkts_lost           = lost;
		it.ts_relay_readback   = ts[0];
		it.voip_relay_readback = vo[0];
		it.banks_differ        = dif[0];
		return it;
	endfunction

	function automatic glfs_pkg::item_t gen_item(bit noise);
		glfs_pkg::item_t it;
		logic [31:0]     raw;
		raw = $urandom;
		it  = raw[$bits(glfs_pkg::item_t)-1:0];
		if (!noise) begin
			it.tick        = ($urandom_range(0, 99) < 55);
			it.lan_up      = ($urandom_range(0, 99) < 88);
			it.manual_mode = ($urandom_range(0, 99) < 2);
			it.ping_done   = ($urandom_range(0, 99) < 22);
			if ($urandom_range(0, 99) < 75)
				it.pkts_sent = reg_val[glfs_pkg::CFG_PING_COUNT][CNT_W-1:0];
			if ($urandom_range(0, 99) < 70)
				it.pkts_lost = CNT_W'($urandom_range(0, 3));
		end
		return it;
	endfunction

	task automatic drain();
		while (pass_queue.size() != 0 || item_ch.valid || pass_want_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_regs(logic [9:0] v0, logic [9:0] v1, logic [9:0] v2, logic [9:0] v3,
			logic [9:0] v4, logic [9:0] v5, logic [9:0] v6, logic [9:0] v7);
		logic [glfs_pkg::CFG_DATA_W-1:0] v [8];
		drain();
		v = '{v0, v1, v2, v3, v4, v5, v6, v7};
		for (int i = 0; i < 8; i++)
			reg_write_q.push_back('{glfs_pkg::cfg_idx_t'(i), v[i]});
		while (reg_write_q.size() != 0 || cfg_ch.valid)
			@(posedge clk);
	endtask

	task automatic load_small_regs();
		load_regs(10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
			10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
			10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
			10'($urandom_range(1, 8)), 10'($urandom_range(0, 3)));
	endtask

	task automatic run_phase(int n, int sat, int unsigned sp, int unsigned rp);
		pend_t p;
		send_pct = sp;
		recv_pct = rp;
		for (int i = 0; i < n; i++) begin
			p.it = gen_item($urandom_range(0, 9) == 0);
			if (i < sat) begin
				p.it.tick        = 1'b1;
				p.it.lan_up      = 1'b0;
				p.it.manual_mode = (i == 0);
			end
			p.hold = ($urandom_range(0, 99) == 0) || (i == n / 2);
			pass_queue.push_back(p);
		end
		drain();
	endtask

	task automatic push_pass(glfs_pkg::item_t it);
		pass_queue.push_back('{it, 1'b0});
	endtask

	initial begin
		send_pct     = 0;
		recv_pct     = 0;
		err_count    = 0;
		result_beats = 0;
		quiet_cycles = 0;
		@(posedge arst_n);
		@(posedge clk);

		load_regs(10'd1, 10'd2, 10'd1, 10'd0, 10'd3, 10'd1, 10'd5, 10'd2);
		push_pass(mk(0, 0, 0, 0, 8'd0, 8'd0, 1, 0, 0));
		push_pass(mk(1, 0, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 0, 0, 0, 8'd255, 8'd255, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(0, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(0, 1, 0, 1, 8'd5, 8'd1, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(0, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(0, 1, 0, 1, 8'd4, 8'd0, 1, 1, 1));
		push_pass(mk(0, 1, 0, 0, 8'd0, 8'd0, 1, 1, 1));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(0, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		// abort the reconfiguration by hand
		push_pass(mk(1, 1, 1, 1, 8'd5, 8'd0, 1, 1, 1));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 1, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(0, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		// good report arriving with the timeout
		push_pass(mk(1, 1, 0, 1, 8'd5, 8'd0, 0, 0, 0));
		push_pass(mk(0, 1, 0, 0, 8'd0, 8'd0, 1, 0, 0));
		push_pass(mk(0, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		push_pass(mk(1, 1, 0, 0, 8'd0, 8'd0, 0, 0, 0));
		drain();

		load_small_regs();
		run_phase(35, 0, 0, 0);
		load_small_regs();
		run_phase(35, 0, 68, 0);
		load_regs(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'h3FF, 10'd255);
		run_phase(35, 0, 0, 68);
		load_regs(10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
			10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
			10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)), 10'h100, 10'd0);
		run_phase(35, 0, 6, 6);
		// hold the wait state past the timer range
		load_regs(10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1, 10'd1);
		run_phase(1040, 1032, 0, 0);
		load_small_regs();
		run_phase(35, 0, 68, 0);
		load_small_regs();
		run_phase(35, 0, 0, 68);
		load_small_regs();
		run_phase(35, 0, 6, 6);
		load_regs(10'd2, 10'd3, 10'd4, 10'd1, 10'd5, 10'd2, 10'd255, 10'd255);
		run_phase(35, 0, 0, 0);

		drain();
		repeat (8) @(posedge clk);
		if (pass_want_q.size() != 0)
			report_mismatch("passes left without a result beat");
		if (err_count == 0)
			$display("tb_gateway_link_failover_supervisor_core passed");
		else
			$display("tb_gateway_link_failover_supervisor_core failed");
		$finish;
	end

endmodule
